// ----- src/mcc_pkg.sv -----
`default_nettype none

package mcc_pkg;

  localparam int POS_W     = 25;
  localparam int ELAPSED_W = 16;
  localparam int RATE_W    = 25;
  localparam int TIME_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_OPEN        = 3'd1,
    OP_CLOSE       = 3'd2,
    OP_STOP        = 3'd3,
    OP_SET_POS     = 3'd4,
    OP_CLEAR_FAULT = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    REG_TRAVEL_RATE    = 2'd0,
    REG_TRAVEL_TIMEOUT = 2'd1,
    REG_OPEN_FITTED    = 2'd2,
    REG_CLOSED_FITTED  = 2'd3
  } reg_idx_t;

  localparam logic signed [1:0] DRIVE_OFF     = 2'sb00;
  localparam logic signed [1:0] DRIVE_OPENING = 2'sb01;
  localparam logic signed [1:0] DRIVE_CLOSING = 2'sb11;

  localparam logic [RATE_W-1:0] RATE_RESET    = 25'd1678;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

  typedef struct packed {
    opcode_t                opcode;
    logic [ELAPSED_W-1:0]   elapsed_ms;
    logic                   open_reading_valid;
    logic                   open_reading;
    logic                   closed_reading_valid;
    logic                   closed_reading;
    logic [POS_W-1:0]       position_value;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0]      drive;
    logic [POS_W-1:0]       position;
    logic                   is_open;
    logic                   is_closed;
    logic                   is_moving;
    logic                   faulted;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/motorized_cover_controller.sv -----
`default_nettype none

// Motorized cover controller. Each beat on the input channel is a command or
// a tick; each produces exactly one status beat on the output channel. A beat
// is taken into an input register, then processed (one 25x16 multiply,
// compare and clamp) into the output register, so the block sustains one
// beat per clock while the output does not stall. While a status beat is
// held by an output stall, the pending beat waits in the input register and
// the input channel stalls in that same cycle; with the input register empty
// a new beat is still taken. Position is a fraction of full travel,
// 2^POSITION_FRACTION_BITS, and the position port carries its low 25 bits.
// Configuration is to be written by the user through the APB-style port
// only while no beat is in flight; the block does not enforce this.
module motorized_cover_controller #(
  parameter int POSITION_FRACTION_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,

  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  mcc_pkg::in_item_t      in_data,

  output logic                         out_valid,
  input  wire                          out_stall,
  output mcc_pkg::out_item_t           out_data,

  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [mcc_pkg::ADDR_W-1:0]   paddr,
  input  wire  [mcc_pkg::DATA_W-1:0]   pwdata,
  output logic [mcc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int PW = POSITION_FRACTION_BITS + 1;
  localparam int CW = (PW > mcc_pkg::POS_W) ? PW : mcc_pkg::POS_W;
  localparam int MW = mcc_pkg::RATE_W + mcc_pkg::ELAPSED_W;
  localparam int TW = mcc_pkg::TIME_W;
  localparam logic [PW-1:0] FULL_POS = {1'b1, {POSITION_FRACTION_BITS{1'b0}}};

  logic [mcc_pkg::RATE_W-1:0] rate_r;
  logic [TW-1:0]              timeout_r;
  logic                       open_fitted_r;
  logic                       closed_fitted_r;

  logic                       in_valid_r;
  mcc_pkg::in_item_t          in_item_r;
  logic                       out_valid_r;
  mcc_pkg::out_item_t         out_item_r, out_item_nxt;

  logic [PW-1:0]              pos_r, pos_nxt;
  logic [PW-1:0]              tgt_r, tgt_nxt;
  logic [TW-1:0]              tt_r, tt_nxt;
  logic                       ol_r, ol_nxt;
  logic                       cl_r, cl_nxt;
  logic                       fault_r, fault_nxt;
  logic signed [1:0]          drive_r, drive_nxt;

  logic                       exec;
  logic                       in_accept;
  logic                       cfg_wr;
  mcc_pkg::reg_idx_t          cfg_idx;

  logic                       t_ol, t_cl;
  logic [PW-1:0]              t_pos;
  logic                       t_up;
  logic [TW:0]                t_sum;
  logic [TW-1:0]              t_tt;
  logic [MW-1:0]              t_prod;
  logic [PW-1:0]              t_step;
  logic [PW-1:0]              t_gap;
  logic [CW-1:0]              pv_ext;
  logic [PW-1:0]              pv_clamp;

  assign exec      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !exec;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign pready  = 1'b1;
  assign cfg_idx = mcc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      mcc_pkg::REG_TRAVEL_RATE:    prdata = mcc_pkg::DATA_W'(rate_r);
      mcc_pkg::REG_TRAVEL_TIMEOUT: prdata = timeout_r;
      mcc_pkg::REG_OPEN_FITTED:    prdata = mcc_pkg::DATA_W'(open_fitted_r);
      mcc_pkg::REG_CLOSED_FITTED:  prdata = mcc_pkg::DATA_W'(closed_fitted_r);
      default:                     prdata = '0;
    endcase
  end

  // tick datapath
  always_comb begin
    t_ol   = (open_fitted_r && in_item_r.open_reading_valid) ?
             in_item_r.open_reading : ol_r;
    t_cl   = (closed_fitted_r && in_item_r.closed_reading_valid) ?
             in_item_r.closed_reading : cl_r;
    t_pos  = t_ol ? FULL_POS : (t_cl ? '0 : pos_r);
    t_up   = tgt_r > t_pos;
    t_sum  = {1'b0, tt_r} + (TW + 1)'(in_item_r.elapsed_ms);
    t_tt   = t_sum[TW] ? {TW{1'b1}} : t_sum[TW-1:0];
    t_prod = MW'(rate_r) * MW'(in_item_r.elapsed_ms);
    t_step = (t_prod > MW'(FULL_POS)) ? FULL_POS : PW'(t_prod);
    t_gap  = t_up ? (tgt_r - t_pos) : (t_pos - tgt_r);
  end

  assign pv_ext   = CW'(in_item_r.position_value);
  assign pv_clamp = (pv_ext > CW'(FULL_POS)) ? FULL_POS : PW'(pv_ext);

  always_comb begin
    pos_nxt   = pos_r;
    tgt_nxt   = tgt_r;
    tt_nxt    = tt_r;
    ol_nxt    = ol_r;
    cl_nxt    = cl_r;
    fault_nxt = fault_r;
    drive_nxt = drive_r;

    unique case (in_item_r.opcode)
      mcc_pkg::OP_TICK: begin
        ol_nxt = t_ol;
        cl_nxt = t_cl;
        if (t_ol && t_cl) begin
          fault_nxt = 1'b1;
          drive_nxt = mcc_pkg::DRIVE_OFF;
        end else if (fault_r || tgt_r == t_pos) begin
          pos_nxt   = t_pos;
          tt_nxt    = '0;
          drive_nxt = mcc_pkg::DRIVE_OFF;
        end else if ((t_up && t_ol) || (!t_up && t_cl)) begin
          pos_nxt   = t_up ? FULL_POS : '0;
          tgt_nxt   = t_up ? FULL_POS : '0;
          tt_nxt    = '0;
          drive_nxt = mcc_pkg::DRIVE_OFF;
        end else if (timeout_r != '0 && t_tt >= timeout_r) begin
          pos_nxt   = t_pos;
          tt_nxt    = t_tt;
          fault_nxt = 1'b1;
          drive_nxt = mcc_pkg::DRIVE_OFF;
        end else if (rate_r == '0 || in_item_r.elapsed_ms == '0) begin
          pos_nxt   = t_pos;
          tt_nxt    = t_tt;
          drive_nxt = t_up ? mcc_pkg::DRIVE_OPENING : mcc_pkg::DRIVE_CLOSING;
        end else if (t_gap <= t_step) begin
          pos_nxt   = tgt_r;
          tt_nxt    = '0;
          drive_nxt = mcc_pkg::DRIVE_OFF;
        end else begin
          pos_nxt   = t_up ? (t_pos + t_step) : (t_pos - t_step);
          tt_nxt    = t_tt;
          drive_nxt = t_up ? mcc_pkg::DRIVE_OPENING : mcc_pkg::DRIVE_CLOSING;
        end
      end
      mcc_pkg::OP_OPEN: begin
        if (!fault_r) begin
          if (tgt_r != FULL_POS) tt_nxt = '0;
          tgt_nxt = FULL_POS;
        end
      end
      mcc_pkg::OP_CLOSE: begin
        if (!fault_r) begin
          if (tgt_r != '0) tt_nxt = '0;
          tgt_nxt = '0;
        end
      end
      mcc_pkg::OP_STOP: begin
        tgt_nxt   = pos_r;
        tt_nxt    = '0;
        drive_nxt = mcc_pkg::DRIVE_OFF;
      end
      mcc_pkg::OP_SET_POS: begin
        pos_nxt = pv_clamp;
        tgt_nxt = pv_clamp;
        tt_nxt  = '0;
      end
      mcc_pkg::OP_CLEAR_FAULT: begin
        fault_nxt = 1'b0;
        tt_nxt    = '0;
      end
      default: begin
      end
    endcase

    out_item_nxt.drive     = drive_nxt;
    out_item_nxt.position  = mcc_pkg::POS_W'(pos_nxt);
    out_item_nxt.is_open   = open_fitted_r ? ol_nxt : (pos_nxt >= FULL_POS);
    out_item_nxt.is_closed = closed_fitted_r ? cl_nxt : (pos_nxt == '0);
    out_item_nxt.is_moving = !fault_nxt && (tgt_nxt != pos_nxt);
    out_item_nxt.faulted   = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r          <= mcc_pkg::RATE_RESET;
      timeout_r       <= mcc_pkg::TIMEOUT_RESET;
      open_fitted_r   <= 1'b0;
      closed_fitted_r <= 1'b0;
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      pos_r           <= '0;
      tgt_r           <= '0;
      tt_r            <= '0;
      ol_r            <= 1'b0;
      cl_r            <= 1'b0;
      fault_r         <= 1'b0;
      drive_r         <= mcc_pkg::DRIVE_OFF;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          mcc_pkg::REG_TRAVEL_RATE:    rate_r <= pwdata[mcc_pkg::RATE_W-1:0];
          mcc_pkg::REG_TRAVEL_TIMEOUT: timeout_r <= pwdata;
          mcc_pkg::REG_OPEN_FITTED:    open_fitted_r <= pwdata[0];
          mcc_pkg::REG_CLOSED_FITTED:  closed_fitted_r <= pwdata[0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (exec) begin
        in_valid_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        tgt_r       <= tgt_nxt;
        tt_r        <= tt_nxt;
        ol_r        <= ol_nxt;
        cl_r        <= cl_nxt;
        fault_r     <= fault_nxt;
        drive_r     <= drive_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_data;
    end
    if (exec) begin
      out_item_r <= out_item_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= FULL_POS) && (tgt_r <= FULL_POS))
    else $error("position or target beyond full travel");

  a_fault_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(fault_r) |-> $past(exec && in_item_r.opcode == mcc_pkg::OP_CLEAR_FAULT))
    else $error("fault cleared without a clear-fault beat");

  a_fault_set: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fault_r) |-> $past(exec && in_item_r.opcode == mcc_pkg::OP_TICK))
    else $error("fault raised outside a tick");

  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !exec) |=> (in_valid_r && $stable(in_item_r)))
    else $error("pending beat lost before processing");
`endif

endmodule

`default_nettype wire
